// File: hw/rtl/sndrf_pkg.sv
// Shared types and port address constants for the sound unit register file.
package sndrf_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanIdxW    = $clog2(NumChannels);

  // Port addresses
  localparam logic [15:0] ADDR_DMA_SRC_LO  = 16'h004a;
  localparam logic [15:0] ADDR_DMA_SRC_MID = 16'h004b;
  localparam logic [15:0] ADDR_DMA_SRC_HI  = 16'h004c;
  localparam logic [15:0] ADDR_DMA_LEN_LO  = 16'h004e;
  localparam logic [15:0] ADDR_DMA_LEN_MID = 16'h004f;
  localparam logic [15:0] ADDR_DMA_LEN_HI  = 16'h0050;
  localparam logic [15:0] ADDR_DMA_CTRL    = 16'h0052;
  localparam logic [15:0] ADDR_HYPER_CTRL  = 16'h006a;
  localparam logic [15:0] ADDR_HYPER_CHAN  = 16'h006b;
  localparam logic [15:0] ADDR_PITCH_BASE  = 16'h0080;
  localparam logic [15:0] ADDR_VOL_BASE    = 16'h0088;
  localparam logic [15:0] ADDR_SWEEP_AMT   = 16'h008c;
  localparam logic [15:0] ADDR_SWEEP_PER   = 16'h008d;
  localparam logic [15:0] ADDR_NOISE_CTRL  = 16'h008e;
  localparam logic [15:0] ADDR_WAVE_BASE   = 16'h008f;
  localparam logic [15:0] ADDR_SND_ENABLE  = 16'h0090;
  localparam logic [15:0] ADDR_OUT_CTRL    = 16'h0091;
  localparam logic [15:0] ADDR_LFSR_LO     = 16'h0092;
  localparam logic [15:0] ADDR_LFSR_HI     = 16'h0093;
  localparam logic [15:0] ADDR_VOICE_ROUTE = 16'h0094;
  localparam logic [15:0] ADDR_HYPER_SMP   = 16'h0095;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Headphone-present bit on the output control port
  localparam logic [7:0] HEADPHONE_PRESENT = 8'h80;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [14:0] noise_lfsr;
    logic [7:0]  hyper_sample;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dma_trigger;
    logic       noise_reset_strobe;
  } result_t;

endpackage

// File: hw/rtl/sound_unit_register_file.sv
// The accepted access is held in the input register and its result word in the output register.
// Throughput: one bus access per cycle while the sink accepts (m_axis_tready); the
//   register bank decodes and updates in a single pass between the input and output registers.
// Reset (rst, synchronous, active high) clears both stage valids and every
//   register field to zero.
// Top level of the sound unit register file.
module sound_unit_register_file (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] write_data, [38:24] noise_lfsr,
  // [46:39] hyper_sample, [47] zero
  input  logic [47:0] s_axis_tdata,
  // [0] action (0 read, 1 write)
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] dma_trigger, [9] noise_reset_strobe, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  sndrf_pkg::access_t acc_in;
  sndrf_pkg::access_t acc;
  sndrf_pkg::result_t res_next;
  sndrf_pkg::result_t res;
  logic               in_valid;
  logic               out_valid;
  logic               advance;

  assign acc_in.action       = s_axis_tuser;
  assign acc_in.address      = s_axis_tdata[15:0];
  assign acc_in.write_data   = s_axis_tdata[23:16];
  assign acc_in.noise_lfsr   = s_axis_tdata[38:24];
  assign acc_in.hyper_sample = s_axis_tdata[46:39];

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  sndrf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .load       (s_axis_tready),
    .word_valid (s_axis_tvalid),
    .acc_in     (acc_in),
    .valid      (in_valid),
    .acc        (acc)
  );

  sndrf_regs u_regs (
    .clk (clk),
    .rst (rst),
    .en  (in_valid && advance),
    .acc (acc),
    .res (res_next)
  );

  sndrf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (in_valid),
    .res_in    (res_next),
    .valid     (out_valid),
    .res       (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, res.noise_reset_strobe, res.dma_trigger, res.read_data};

endmodule

// File: hw/rtl/sndrf_in_stage.sv
// Input register stage: holds one accepted bus access.
module sndrf_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               word_valid,
  input  sndrf_pkg::access_t acc_in,
  output logic               valid,
  output sndrf_pkg::access_t acc
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && word_valid) begin
      acc <= acc_in;
    end
  end

endmodule

// File: hw/rtl/sndrf_regs.sv
// Register bank: address decode, field updates, strobes and read mux.
module sndrf_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  sndrf_pkg::access_t acc,
  output sndrf_pkg::result_t res
);

  logic [19:0] dma_source_setting;
  logic [19:0] dma_length_setting;
  logic [19:0] dma_source_current;
  logic [19:0] dma_length_current;
  logic [6:0]  dma_control_bits;
  logic [7:0]  hyper_control_bits;
  logic [5:0]  hyper_channel_bits;
  logic [11:0] channel_pitch [sndrf_pkg::NumChannels];
  logic [7:0]  channel_volume [sndrf_pkg::NumChannels];
  logic [7:0]  sweep_amount;
  logic [4:0]  sweep_period;
  logic [4:0]  noise_control_bits;
  logic [7:0]  wave_table_base;
  logic [6:0]  sound_enable_bits;
  logic [3:0]  output_control_bits;
  logic [3:0]  voice_route_bits;

  logic                          is_write;
  logic                          hit_pitch;
  logic                          hit_vol;
  logic [sndrf_pkg::ChanIdxW-1:0] pitch_idx;
  logic [sndrf_pkg::ChanIdxW-1:0] vol_idx;
  logic [7:0]                    d;
  logic                          trig;
  logic [7:0]                    rd;

  assign is_write  = (acc.action == sndrf_pkg::ACT_WRITE);
  assign d         = acc.write_data;
  // pitch ports: two per channel, low byte on the even address
  assign hit_pitch = (acc.address[15:3] == sndrf_pkg::ADDR_PITCH_BASE[15:3]);
  assign hit_vol   = (acc.address[15:2] == sndrf_pkg::ADDR_VOL_BASE[15:2]);
  assign pitch_idx = acc.address[sndrf_pkg::ChanIdxW:1];
  assign vol_idx   = acc.address[sndrf_pkg::ChanIdxW-1:0];
  // DMA starts only on a 0 -> 1 edge of the enable bit
  assign trig      = is_write && (acc.address == sndrf_pkg::ADDR_DMA_CTRL)
                     && !dma_control_bits[6] && d[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      dma_source_setting  <= '0;
      dma_length_setting  <= '0;
      dma_source_current  <= '0;
      dma_length_current  <= '0;
      dma_control_bits    <= '0;
      hyper_control_bits  <= '0;
      hyper_channel_bits  <= '0;
      for (int i = 0; i < sndrf_pkg::NumChannels; i++) begin
        channel_pitch[i]  <= '0;
        channel_volume[i] <= '0;
      end
      sweep_amount        <= '0;
      sweep_period        <= '0;
      noise_control_bits  <= '0;
      wave_table_base     <= '0;
      sound_enable_bits   <= '0;
      output_control_bits <= '0;
      voice_route_bits    <= '0;
    end else if (en && is_write) begin
      if (hit_pitch) begin
        if (acc.address[0]) begin
          channel_pitch[pitch_idx][11:8] <= d[3:0];
        end else begin
          channel_pitch[pitch_idx][7:0] <= d;
        end
      end else if (hit_vol) begin
        channel_volume[vol_idx] <= d;
      end else begin
        unique case (acc.address)
          sndrf_pkg::ADDR_DMA_SRC_LO:  dma_source_setting[7:0]   <= d;
          sndrf_pkg::ADDR_DMA_SRC_MID: dma_source_setting[15:8]  <= d;
          sndrf_pkg::ADDR_DMA_SRC_HI:  dma_source_setting[19:16] <= d[3:0];
          sndrf_pkg::ADDR_DMA_LEN_LO:  dma_length_setting[7:0]   <= d;
          sndrf_pkg::ADDR_DMA_LEN_MID: dma_length_setting[15:8]  <= d;
          sndrf_pkg::ADDR_DMA_LEN_HI:  dma_length_setting[19:16] <= d[3:0];
          sndrf_pkg::ADDR_DMA_CTRL: begin
            if (trig) begin
              dma_source_current <= dma_source_setting;
              dma_length_current <= dma_length_setting;
            end
            dma_control_bits <= {d[7:6], d[4:0]};
          end
          sndrf_pkg::ADDR_HYPER_CTRL:  hyper_control_bits  <= d;
          sndrf_pkg::ADDR_HYPER_CHAN:  hyper_channel_bits  <= {d[6:5], d[3:0]};
          sndrf_pkg::ADDR_SWEEP_AMT:   sweep_amount        <= d;
          sndrf_pkg::ADDR_SWEEP_PER:   sweep_period        <= d[4:0];
          sndrf_pkg::ADDR_NOISE_CTRL:  noise_control_bits  <= d[4:0];
          sndrf_pkg::ADDR_WAVE_BASE:   wave_table_base     <= d;
          sndrf_pkg::ADDR_SND_ENABLE:  sound_enable_bits   <= {d[7:5], d[3:0]};
          sndrf_pkg::ADDR_OUT_CTRL:    output_control_bits <= d[3:0];
          sndrf_pkg::ADDR_VOICE_ROUTE: voice_route_bits    <= d[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rd = '0;
    if (hit_pitch) begin
      rd = acc.address[0] ? {4'b0, channel_pitch[pitch_idx][11:8]}
                          : channel_pitch[pitch_idx][7:0];
    end else if (hit_vol) begin
      rd = channel_volume[vol_idx];
    end else begin
      unique case (acc.address)
        sndrf_pkg::ADDR_DMA_SRC_LO:  rd = dma_source_current[7:0];
        sndrf_pkg::ADDR_DMA_SRC_MID: rd = dma_source_current[15:8];
        sndrf_pkg::ADDR_DMA_SRC_HI:  rd = {4'b0, dma_source_current[19:16]};
        sndrf_pkg::ADDR_DMA_LEN_LO:  rd = dma_length_current[7:0];
        sndrf_pkg::ADDR_DMA_LEN_MID: rd = dma_length_current[15:8];
        sndrf_pkg::ADDR_DMA_LEN_HI:  rd = {4'b0, dma_length_current[19:16]};
        sndrf_pkg::ADDR_DMA_CTRL:    rd = {dma_control_bits[6:5], 1'b0,
                                           dma_control_bits[4:0]};
        sndrf_pkg::ADDR_HYPER_CTRL:  rd = hyper_control_bits;
        sndrf_pkg::ADDR_HYPER_CHAN:  rd = {1'b0, hyper_channel_bits[5:4], 1'b0,
                                           hyper_channel_bits[3:0]};
        sndrf_pkg::ADDR_SWEEP_AMT:   rd = sweep_amount;
        sndrf_pkg::ADDR_SWEEP_PER:   rd = {3'b0, sweep_period};
        // reset bit never reads back
        sndrf_pkg::ADDR_NOISE_CTRL:  rd = {3'b0, noise_control_bits[4], 1'b0,
                                           noise_control_bits[2:0]};
        sndrf_pkg::ADDR_WAVE_BASE:   rd = wave_table_base;
        sndrf_pkg::ADDR_SND_ENABLE:  rd = {sound_enable_bits[6:4], 1'b0,
                                           sound_enable_bits[3:0]};
        sndrf_pkg::ADDR_OUT_CTRL:    rd = {4'b0, output_control_bits}
                                          | sndrf_pkg::HEADPHONE_PRESENT;
        sndrf_pkg::ADDR_LFSR_LO:     rd = acc.noise_lfsr[7:0];
        sndrf_pkg::ADDR_LFSR_HI:     rd = {1'b0, acc.noise_lfsr[14:8]};
        sndrf_pkg::ADDR_VOICE_ROUTE: rd = {4'b0, voice_route_bits};
        sndrf_pkg::ADDR_HYPER_SMP:   rd = acc.hyper_sample;
        default:                     rd = '0;
      endcase
    end
  end

  assign res.read_data          = is_write ? 8'h00 : rd;
  assign res.dma_trigger        = trig;
  assign res.noise_reset_strobe = is_write
                                  && (acc.address == sndrf_pkg::ADDR_NOISE_CTRL) && d[3];

endmodule

// File: hw/rtl/sndrf_out_stage.sv
// Output register stage: holds one result word until the sink takes it.
module sndrf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               res_valid,
  input  sndrf_pkg::result_t res_in,
  output logic               valid,
  output sndrf_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res <= res_in;
    end
  end

endmodule
